// ===== rtl/lkvc_pkg.sv =====
// ============================================================================
// lkvc_pkg
// Shared types and constants for the LRU key/value cache: store geometry,
// operation codes and the request and result records.
// ============================================================================
package lkvc_pkg;

    // Store geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W   = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Capacity register reset value and miss marker
    localparam logic [CAP_W-1:0]         CAP_RESET = CAP_W'(16);
    localparam logic signed [DATA_W-1:0] MISS_DATA = -DATA_W'(1);

    // Operation codes
    typedef enum logic {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } t_kind;

    // One request as held in the input register
    typedef struct packed {
        t_kind                    kind;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
    } t_req;

    // One result as produced by the store
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] data;
        logic                     evicted;
    } t_res;

endpackage

// ===== rtl/lkvc_store.sv =====
// ============================================================================
// lkvc_store
// Fully associative entry store: parallel key compare, recency ranks,
// eviction of the oldest ranks and insertion into the lowest free slot,
// all resolved combinationally for each request.
// ============================================================================
module lkvc_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  lkvc_pkg::t_req                  i_req,
    input  logic [lkvc_pkg::CAP_W-1:0]      i_cap,
    output lkvc_pkg::t_res                  o_res,
    output logic [lkvc_pkg::OCC_W-1:0]      o_occ
);

    localparam int N = lkvc_pkg::ENTRIES;

    logic signed [lkvc_pkg::KEY_W-1:0]  r_key [N];
    logic signed [lkvc_pkg::DATA_W-1:0] r_val [N];
    logic [N-1:0]                       r_valid;
    logic [N-1:0]                       n_valid;
    logic [lkvc_pkg::AGE_W-1:0]         r_age [N];
    logic [lkvc_pkg::AGE_W-1:0]         n_age [N];
    logic [lkvc_pkg::OCC_W-1:0]         r_occ;
    logic [lkvc_pkg::OCC_W-1:0]         n_occ;

    logic [N-1:0]                       match;
    logic                               hit;
    logic signed [lkvc_pkg::DATA_W-1:0] hit_val;
    logic [lkvc_pkg::AGE_W-1:0]         hit_age;
    logic [lkvc_pkg::OCC_W-1:0]         cap;
    logic [lkvc_pkg::OCC_W-1:0]         cap_m1;
    logic                               is_put;
    logic                               do_evict;
    logic [N-1:0]                       evict_mask;
    logic [N-1:0]                       free;
    logic [N-1:0]                       ins;

    // Clamp the capacity register into 1..ENTRIES
    always_comb begin
        if (i_cap == '0) begin
            cap = lkvc_pkg::OCC_W'(1);
        end else if (int'(i_cap) > N) begin
            cap = lkvc_pkg::OCC_W'(N);
        end else begin
            cap = lkvc_pkg::OCC_W'(i_cap);
        end
        cap_m1 = cap - lkvc_pkg::OCC_W'(1);
    end

    // Compare every valid entry with the key; keys are unique, so OR the hits
    always_comb begin
        hit_val = '0;
        hit_age = '0;
        for (int i = 0; i < N; i++) begin
            match[i] = r_valid[i] && (r_key[i] == i_req.key);
            if (match[i]) begin
                hit_val = hit_val | r_val[i];
                hit_age = hit_age | r_age[i];
            end
        end
        hit = |match;
    end

    // On a put miss at capacity, drop every entry ranked cap-1 or older
    always_comb begin
        is_put   = (i_req.kind == lkvc_pkg::KIND_PUT);
        do_evict = is_put && !hit && (r_occ >= cap);
        for (int i = 0; i < N; i++) begin
            evict_mask[i] = do_evict && r_valid[i] &&
                            (lkvc_pkg::OCC_W'(r_age[i]) >= cap_m1);
        end
        free = ~r_valid | evict_mask;
        // Lowest free slot as a one-hot vector
        ins  = free & (~free + N'(1));
    end

    // Next ranks, valid bits and occupancy
    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        for (int i = 0; i < N; i++) begin
            n_age[i] = r_age[i];
            if (hit) begin
                if (match[i]) begin
                    n_age[i] = '0;
                end else if (r_valid[i] && (r_age[i] < hit_age)) begin
                    n_age[i] = r_age[i] + lkvc_pkg::AGE_W'(1);
                end
            end else if (is_put) begin
                if (ins[i]) begin
                    n_valid[i] = 1'b1;
                    n_age[i]   = '0;
                end else if (evict_mask[i]) begin
                    // Drop an evicted entry that the new key does not reuse
                    n_valid[i] = 1'b0;
                    n_age[i]   = '0;
                end else if (r_valid[i]) begin
                    n_age[i] = r_age[i] + lkvc_pkg::AGE_W'(1);
                end
            end
        end
        if (!hit && is_put) begin
            n_occ = do_evict ? cap : (r_occ + lkvc_pkg::OCC_W'(1));
        end
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < N; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_en) begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            for (int i = 0; i < N; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    // Write keys and values: overwrite on a put hit, fill on a put miss
    always_ff @(posedge i_clk) begin
        if (i_en && is_put) begin
            for (int i = 0; i < N; i++) begin
                if (hit ? match[i] : ins[i]) begin
                    r_val[i] <= i_req.value;
                end
                if (!hit && ins[i]) begin
                    r_key[i] <= i_req.key;
                end
            end
        end
    end

    // Form the result
    always_comb begin
        o_res.hit     = hit;
        o_res.evicted = do_evict;
        if (is_put) begin
            o_res.data = i_req.value;
        end else if (hit) begin
            o_res.data = hit_val;
        end else begin
            o_res.data = lkvc_pkg::MISS_DATA;
        end
    end

    assign o_occ = r_occ;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// ============================================================================
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ============================================================================
// A request is held in the input register; when it advances, the same edge
// updates the store and loads the result register.
// Throughput: one request per cycle while results drain; the combinational store
// lookup and rank update set the rate; only a waiting result stalls it.
// Reset (synchronous, active low): store empty, capacity register 16.
// ============================================================================
module lru_key_value_cache (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic signed [lkvc_pkg::KEY_W-1:0]    i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0]   i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0]   o_data,
    output logic                                 o_evicted,
    input  logic                                 i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]           i_cfg_wdata
);

    logic [lkvc_pkg::CAP_W-1:0] r_cap;
    logic                       r_in_valid;
    lkvc_pkg::t_req             r_req;
    logic                       r_out_valid;
    lkvc_pkg::t_res             r_res;
    lkvc_pkg::t_res             lookup;
    logic [lkvc_pkg::OCC_W-1:0] occ;
    logic                       advance;

    // Process the held request when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Input register: take a new request whenever there is room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req.kind  <= lkvc_pkg::t_kind'(i_kind);
            r_req.key   <= i_key;
            r_req.value <= i_value;
        end
    end

    lkvc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_req   (r_req),
        .i_cap   (r_cap),
        .o_res   (lookup),
        .o_occ   (occ)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= lookup;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_res.hit;
    assign o_data      = r_res.data;
    assign o_evicted   = r_res.evicted;

    // Occupancy never exceeds the number of slots
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(occ) <= lkvc_pkg::ENTRIES)
        else $error("occupancy above slot count");

    // Eviction only on a put that missed
    a_evict_put_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && lookup.evicted |->
            (r_req.kind == lkvc_pkg::KIND_PUT) && !lookup.hit)
        else $error("eviction outside a put miss");

    // A processed put leaves the store non-empty
    a_put_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_req.kind == lkvc_pkg::KIND_PUT) |=> occ != '0)
        else $error("store empty after put");

    // A get never changes occupancy
    a_get_keeps_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_req.kind == lkvc_pkg::KIND_GET) |=> $stable(occ))
        else $error("get changed occupancy");

endmodule
